// File: hdl/bsc_pkg.sv
`timescale 1ns / 1ps
package bsc_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OFFSET      = 3'd0,
        CFG_SENSITIVITY = 3'd1,
        CFG_TEMP_LINEAR = 3'd2,
        CFG_PRESS_SQ    = 3'd3,
        CFG_TEMP_CURVE  = 3'd4,
        CFG_OVERSAMPLE  = 3'd5
    } cfg_index_t;

    localparam logic [31:0] RESET_OFFSET      = 32'd26804152;
    localparam logic [31:0] RESET_SENSITIVITY = 32'd3352395749;
    localparam logic [31:0] RESET_TEMP_LINEAR = 32'd2146785905;
    localparam logic [31:0] RESET_PRESS_SQ    = 32'd405667844;
    localparam logic [31:0] RESET_TEMP_CURVE  = 32'd3724086068;
    localparam logic [1:0]  RESET_OVERSAMPLE  = 2'd3;

    localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
    localparam logic        [31:0] B4_BIAS    = 32'd32768;
    localparam logic        [31:0] OSS_SCALE  = 32'd50000;
    localparam logic signed [31:0] P_SQ_GAIN  = 32'sd3038;
    localparam logic signed [31:0] P_LIN_GAIN = -32'sd7357;
    localparam logic signed [31:0] P_OFFSET   = 32'sd3791;
    localparam logic signed [31:0] T_MAX      = 32'sd32767;
    localparam logic signed [31:0] T_MIN      = -32'sd32768;

    typedef struct packed {
        logic [31:0] offset_pair;
        logic [31:0] sens_pair;
        logic [31:0] tlin_pair;
        logic [31:0] psq_pair;
        logic [31:0] tcurve_pair;
        logic [1:0]  oss;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] x1;
        logic        [31:0] up;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic signed [31:0] sx16(input logic [15:0] v);
        sx16 = $signed({{16{v[15]}}, v});
    endfunction

    function automatic logic [15:0] oss_scale(input logic [1:0] oss);
        oss_scale = 16'(OSS_SCALE >> oss);
    endfunction

endpackage

// File: hdl/bsc_if.sv
`timescale 1ns / 1ps
interface bsc_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure_bytes;
    modport source (output valid, raw_temperature, raw_pressure_bytes, input ready);
    modport sink   (input valid, raw_temperature, raw_pressure_bytes, output ready);
endinterface

interface bsc_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temperature_tenths;
    logic signed [31:0] pressure_pascal;
    logic               status;
    modport source (output valid, temperature_tenths, pressure_pascal, status, input ready);
    modport sink   (input valid, temperature_tenths, pressure_pascal, status, output ready);
endinterface

interface bsc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bsc_pkg::CFG_INDEX_W-1:0]   index;
    logic [31:0]                       data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/bsc_queue.sv
`timescale 1ns / 1ps
module bsc_queue #(
    parameter int W     = bsc_pkg::ENTRY_W,
    parameter int DEPTH = bsc_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] head,
    output logic         empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        bump = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

// File: hdl/bsc_front.sv
`timescale 1ns / 1ps
module bsc_front (
    input  logic                    clk,
    input  logic                    rst_n,
    bsc_sample_if.sink              sample,
    input  bsc_pkg::cfg_t           cfg,
    input  logic                    q_full,
    output logic                    q_push,
    output bsc_pkg::entry_t         q_entry
);
    logic        valid_reg;
    logic [15:0] ut_reg;
    logic [31:0] up_reg;

    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic        [31:0] up_next;

    assign q_push       = valid_reg && !q_full;
    assign sample.ready = !valid_reg || !q_full;

    // raw pressure drops 8 - oss low bits
    assign up_next = 32'({8'd0, sample.raw_pressure_bytes} >> (4'd8 - {2'b00, cfg.oss}));

    assign diff = $signed({1'b0, ut_reg}) - $signed({1'b0, cfg.tlin_pair[15:0]});
    assign prod = diff * $signed({1'b0, cfg.tlin_pair[31:16]});

    always_comb
    begin
        q_entry.x1 = $signed(prod[31:0]) >>> 15;
        q_entry.up = up_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
        begin
            ut_reg <= sample.raw_temperature;
            up_reg <= up_next;
        end
    end
endmodule

// File: hdl/bsc_div.sv
`timescale 1ns / 1ps
module bsc_div #(
    parameter int N = 32,
    parameter int W = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic [N-1:0] dividend,
    input  logic [N-1:0] divisor,
    input  logic [W-1:0] side_in,
    output logic         out_valid,
    output logic [N-1:0] quotient,
    output logic [W-1:0] side_out
);
    // one quotient bit per stage, restoring
    logic         v   [N+1];
    logic [N-1:0] rem [N+1];
    logic [N-1:0] dvd [N+1];
    logic [N-1:0] dvs [N+1];
    logic [W-1:0] sd  [N+1];

    assign v[0]   = in_valid;
    assign rem[0] = '0;
    assign dvd[0] = dividend;
    assign dvs[0] = divisor;
    assign sd[0]  = side_in;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [N:0] trial;
        logic [N:0] diffv;
        logic       take;

        assign trial = {rem[k], dvd[k][N-1]};
        assign diffv = trial - {1'b0, dvs[k]};
        assign take  = !diffv[N];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v[k+1] <= v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem[k+1] <= take ? diffv[N-1:0] : trial[N-1:0];
                dvd[k+1] <= {dvd[k][N-2:0], take};
                dvs[k+1] <= dvs[k];
                sd[k+1]  <= sd[k];
            end
        end
    end

    assign out_valid = v[N];
    assign quotient  = dvd[N];
    assign side_out  = sd[N];
endmodule

// File: hdl/bsc_back.sv
`timescale 1ns / 1ps
module bsc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  bsc_pkg::cfg_t   cfg,
    input  logic            q_empty,
    input  bsc_pkg::entry_t q_head,
    output logic            q_pop,
    bsc_result_if.source    result
);
    logic en;
    assign en    = !result.valid || result.ready;
    assign q_pop = !q_empty && en;

    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic        [15:0] ac4;
    always_comb
    begin
        ac1 = bsc_pkg::sx16(cfg.offset_pair[31:16]);
        ac2 = bsc_pkg::sx16(cfg.offset_pair[15:0]);
        ac3 = bsc_pkg::sx16(cfg.sens_pair[31:16]);
        ac4 = cfg.sens_pair[15:0];
        b1  = bsc_pkg::sx16(cfg.psq_pair[31:16]);
        b2  = bsc_pkg::sx16(cfg.psq_pair[15:0]);
        mc  = bsc_pkg::sx16(cfg.tcurve_pair[31:16]);
        md  = bsc_pkg::sx16(cfg.tcurve_pair[15:0]);
    end

    // temperature divide: mc * 2048 / (x1 + md), sign handled around the magnitudes
    localparam int SIDE1_W = 32 + 32 + 2;
    logic signed [31:0] den, num;
    logic        [31:0] mag_n, mag_d;
    logic               neg;
    always_comb
    begin
        den   = q_head.x1 + md;
        num   = mc <<< 11;
        neg   = num[31] ^ den[31];
        mag_n = num[31] ? 32'(-num) : num;
        mag_d = den[31] ? 32'(-den) : den;
    end

    logic               d1_valid;
    logic        [31:0] d1_q;
    logic [SIDE1_W-1:0] d1_side;

    bsc_div #(.N(32), .W(SIDE1_W)) u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_pop),
        .dividend  (mag_n),
        .divisor   (mag_d),
        .side_in   ({q_head.x1, q_head.up, neg, den == '0}),
        .out_valid (d1_valid),
        .quotient  (d1_q),
        .side_out  (d1_side)
    );

    logic signed [31:0] d1_x1;
    logic        [31:0] d1_up;
    logic               d1_neg, d1_zero;
    assign {d1_x1, d1_up, d1_neg, d1_zero} = d1_side;

    // stage 1: b5, temperature, b6
    logic signed [31:0] q1, b5, tr;
    logic signed [15:0] t_sat;
    always_comb
    begin
        q1 = d1_neg ? $signed(32'(-d1_q)) : $signed(d1_q);
        b5 = d1_x1 + q1;
        tr = (b5 + 32'sd8) >>> 4;
        if (tr > bsc_pkg::T_MAX)
        begin
            t_sat = 16'sh7FFF;
        end
        else if (tr < bsc_pkg::T_MIN)
        begin
            t_sat = 16'sh8000;
        end
        else
        begin
            t_sat = tr[15:0];
        end
    end

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic               s5_valid_reg, s6_valid_reg, s7_valid_reg, s8_valid_reg;
    logic               out_valid_reg;
    logic signed [15:0] s1_t_reg, s2_t_reg, s3_t_reg, s4_t_reg, s5_t_reg, s6_t_reg;
    logic               s1_z_reg, s2_z_reg, s3_z_reg, s4_z_reg, s5_z_reg, s6_z_reg;
    logic        [31:0] s1_up_reg, s2_up_reg, s3_up_reg, s4_up_reg;
    logic signed [31:0] s1_b6_reg;
    logic signed [31:0] s2_sq_reg, s2_x2a_reg, s2_x1c_reg;
    logic signed [31:0] s3_x1b_reg, s3_x2b_reg, s3_x2a_reg, s3_x1c_reg;
    logic signed [31:0] s4_b3_reg, s4_x3b_reg;
    logic        [31:0] s5_b4_reg, s5_d_reg;
    logic        [31:0] s6_b4_reg, s6_b7_reg;

    // stage 2 products
    logic signed [31:0] m_sq, m_ac2, m_ac3;
    assign m_sq  = s1_b6_reg * s1_b6_reg;
    assign m_ac2 = ac2 * s1_b6_reg;
    assign m_ac3 = ac3 * s1_b6_reg;

    // stage 3 products
    logic signed [31:0] m_b2, m_b1;
    assign m_b2 = b2 * s2_sq_reg;
    assign m_b1 = b1 * s2_sq_reg;

    // stage 4: b3 and x3
    logic signed [31:0] x3a, b3a, b3b, x3s;
    always_comb
    begin
        x3a = s3_x1b_reg + s3_x2a_reg;
        b3a = (ac1 <<< 2) + x3a;
        b3b = (b3a <<< cfg.oss) + 32'sd2;
        x3s = s3_x1c_reg + s3_x2b_reg + 32'sd2;
    end

    // stage 5: b4 and up - b3
    logic [31:0] b4u;
    logic [47:0] b4p;
    assign b4u = s4_x3b_reg + bsc_pkg::B4_BIAS;
    assign b4p = {32'd0, ac4} * {16'd0, b4u};

    // stage 6: b7
    logic [47:0] b7p;
    assign b7p = {16'd0, s5_d_reg} * {32'd0, bsc_pkg::oss_scale(cfg.oss)};

    // pressure divide: either (b7 * 2) / b4, or (b7 / b4) * 2 when b7 has its top bit set
    localparam int SIDE2_W = 16 + 2;
    logic        [31:0] dvd2;
    logic               dbl;
    assign dbl  = s6_b7_reg[31];
    assign dvd2 = dbl ? s6_b7_reg : {s6_b7_reg[30:0], 1'b0};

    logic               d2_valid;
    logic        [31:0] d2_q;
    logic [SIDE2_W-1:0] d2_side;

    bsc_div #(.N(32), .W(SIDE2_W)) u_div_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_valid_reg),
        .dividend  (dvd2),
        .divisor   (s6_b4_reg),
        .side_in   ({s6_t_reg, s6_z_reg, dbl}),
        .out_valid (d2_valid),
        .quotient  (d2_q),
        .side_out  (d2_side)
    );

    logic signed [15:0] d2_t;
    logic               d2_z, d2_dbl;
    assign {d2_t, d2_z, d2_dbl} = d2_side;

    // stage 7: p and its first products
    logic signed [31:0] pp, ps, m_pp, m_lin;
    always_comb
    begin
        pp    = d2_dbl ? $signed({d2_q[30:0], 1'b0}) : $signed(d2_q);
        ps    = pp >>> 8;
        m_pp  = ps * ps;
        m_lin = bsc_pkg::P_LIN_GAIN * pp;
    end

    logic signed [31:0] s7_pp_reg, s7_x1_reg, s7_x2_reg;
    logic signed [15:0] s7_t_reg;
    logic               s7_z_reg;
    logic signed [31:0] s8_pp_reg, s8_x1_reg, s8_x2_reg;
    logic signed [15:0] s8_t_reg;
    logic               s8_z_reg;

    logic signed [31:0] m_sqg;
    assign m_sqg = s7_x1_reg * bsc_pkg::P_SQ_GAIN;

    logic signed [31:0] pres, corr;
    assign corr = (s8_x1_reg + s8_x2_reg + bsc_pkg::P_OFFSET) >>> 4;
    assign pres = s8_pp_reg + corr;

    logic signed [15:0] out_t_reg;
    logic signed [31:0] out_p_reg;
    logic               out_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= d1_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= d2_valid;
            s8_valid_reg  <= s7_valid_reg;
            out_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_t_reg   <= t_sat;
            s1_z_reg   <= d1_zero;
            s1_up_reg  <= d1_up;
            s1_b6_reg  <= b5 - bsc_pkg::B6_OFFSET;

            s2_t_reg   <= s1_t_reg;
            s2_z_reg   <= s1_z_reg;
            s2_up_reg  <= s1_up_reg;
            s2_sq_reg  <= m_sq >>> 12;
            s2_x2a_reg <= m_ac2 >>> 11;
            s2_x1c_reg <= m_ac3 >>> 13;

            s3_t_reg   <= s2_t_reg;
            s3_z_reg   <= s2_z_reg;
            s3_up_reg  <= s2_up_reg;
            s3_x1b_reg <= m_b2 >>> 11;
            s3_x2b_reg <= m_b1 >>> 16;
            s3_x2a_reg <= s2_x2a_reg;
            s3_x1c_reg <= s2_x1c_reg;

            s4_t_reg   <= s3_t_reg;
            s4_z_reg   <= s3_z_reg;
            s4_up_reg  <= s3_up_reg;
            s4_b3_reg  <= b3b >>> 2;
            s4_x3b_reg <= x3s >>> 2;

            s5_t_reg   <= s4_t_reg;
            s5_z_reg   <= s4_z_reg;
            s5_b4_reg  <= {15'd0, b4p[31:15]};
            s5_d_reg   <= s4_up_reg - s4_b3_reg;

            s6_t_reg   <= s5_t_reg;
            s6_z_reg   <= s5_z_reg || (s5_b4_reg == '0);
            s6_b4_reg  <= s5_b4_reg;
            s6_b7_reg  <= b7p[31:0];

            s7_t_reg   <= d2_t;
            s7_z_reg   <= d2_z;
            s7_pp_reg  <= pp;
            s7_x1_reg  <= m_pp;
            s7_x2_reg  <= m_lin >>> 16;

            s8_t_reg   <= s7_t_reg;
            s8_z_reg   <= s7_z_reg;
            s8_pp_reg  <= s7_pp_reg;
            s8_x1_reg  <= m_sqg >>> 16;
            s8_x2_reg  <= s7_x2_reg;

            // a zero divisor forces both fields to zero
            out_t_reg  <= s8_z_reg ? '0 : s8_t_reg;
            out_p_reg  <= s8_z_reg ? '0 : pres;
            out_s_reg  <= s8_z_reg;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.temperature_tenths = out_t_reg;
    assign result.pressure_pascal    = out_p_reg;
    assign result.status             = out_s_reg;
endmodule

// File: hdl/barometric_sensor_compensation.sv
`timescale 1ns / 1ps
// Channel   Role   Beat contents
// sample    sink   raw_temperature[15:0], raw_pressure_bytes[23:0]
// result    source temperature_tenths[15:0], pressure_pascal[31:0], status
// cfg       sink   index[2:0], data[31:0]; always ready
//
// One sample beat per cycle sustained while result beats are taken; each beat
// passes through two 32-stage restoring dividers on its way to its result beat.
// Reset (rst_n low, asynchronous) empties every stage and loads the default
// calibration. A stalled result holds the back pipeline; the queue and the
// front register keep taking beats until the queue fills.
module barometric_sensor_compensation #(
    parameter int QUEUE_DEPTH = bsc_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    bsc_sample_if.sink   sample,
    bsc_result_if.source result,
    bsc_cfg_if.sink      cfg
);
    bsc_pkg::cfg_t cfg_reg;

    assign cfg.ready = 1'b1;

    // write the addressed register; drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_pair <= bsc_pkg::RESET_OFFSET;
            cfg_reg.sens_pair   <= bsc_pkg::RESET_SENSITIVITY;
            cfg_reg.tlin_pair   <= bsc_pkg::RESET_TEMP_LINEAR;
            cfg_reg.psq_pair    <= bsc_pkg::RESET_PRESS_SQ;
            cfg_reg.tcurve_pair <= bsc_pkg::RESET_TEMP_CURVE;
            cfg_reg.oss         <= bsc_pkg::RESET_OVERSAMPLE;
        end
        else if (cfg.valid)
        begin
            case (bsc_pkg::cfg_index_t'(cfg.index))
                bsc_pkg::CFG_OFFSET:      cfg_reg.offset_pair <= cfg.data;
                bsc_pkg::CFG_SENSITIVITY: cfg_reg.sens_pair   <= cfg.data;
                bsc_pkg::CFG_TEMP_LINEAR: cfg_reg.tlin_pair   <= cfg.data;
                bsc_pkg::CFG_PRESS_SQ:    cfg_reg.psq_pair    <= cfg.data;
                bsc_pkg::CFG_TEMP_CURVE:  cfg_reg.tcurve_pair <= cfg.data;
                bsc_pkg::CFG_OVERSAMPLE:  cfg_reg.oss         <= cfg.data[1:0];
                default:                  ;
            endcase
        end
    end

    logic            q_push, q_full, q_pop, q_empty;
    bsc_pkg::entry_t q_in, q_head;
    logic [bsc_pkg::ENTRY_W-1:0] q_head_bits;

    // front: register the beat, shift the pressure, form x1
    bsc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_in)
    );

    bsc_queue #(.W(bsc_pkg::ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head_bits),
        .empty     (q_empty)
    );

    assign q_head = bsc_pkg::entry_t'(q_head_bits);

    // back: both divides and the compensation polynomial, advancing together
    bsc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .result  (result)
    );
endmodule

// File: hdl/bsc_checker.sv
`timescale 1ns / 1ps
module bsc_props (
    input logic        clk,
    input logic        rst_n,
    input logic        r_valid,
    input logic        r_ready,
    input logic [15:0] r_temp,
    input logic [31:0] r_pres,
    input logic        r_status,
    input logic        c_ready
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid)
        else $error("result beat dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> $stable(r_temp) && $stable(r_pres) && $stable(r_status))
        else $error("stalled result beat changed");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && r_status |-> r_temp == '0 && r_pres == '0)
        else $error("zero divisor beat carries nonzero fields");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        c_ready)
        else $error("configuration port not ready");
endmodule

bind barometric_sensor_compensation bsc_props u_bsc_props (
    .clk      (clk),
    .rst_n    (rst_n),
    .r_valid  (result.valid),
    .r_ready  (result.ready),
    .r_temp   (result.temperature_tenths),
    .r_pres   (result.pressure_pascal),
    .r_status (result.status),
    .c_ready  (cfg.ready)
);

// File: dv/bsc_checker.sv
`timescale 1ns / 1ps
module bsc_checker (
    input  logic  clk,
    input  logic  rst_n,
    bsc_sample_if sample,
    bsc_result_if result,
    bsc_cfg_if    cfg,
    output int    mismatches,
    output int    outstanding
);
    import bsc_pkg::*;

    typedef struct {
        logic signed [15:0] tenths;
        logic signed [31:0] pascal;
        logic               stat;
    } reading_t;

    logic [31:0] coef [5];
    logic [1:0]  oss_lvl;
    reading_t    due_q[$];

    function automatic longint wrap32(input longint v);
        return longint'($signed(v[31:0]));
    endfunction

    function automatic longint hs(input logic [15:0] h);
        return longint'($signed(h));
    endfunction

    function automatic reading_t compensate(input logic [15:0] ut_raw,
                                            input logic [23:0] up_raw);
        reading_t r;
        longint   off1, off2, sens3, gain5, toff6, sq1, sq2, crv, cofs;
        longint   lin, den, corr, b5v, tv, d6, sqr, a, b, c, b3v, pv, fin;
        logic [63:0] wide;
        logic [31:0] upv, b4v, b7v, pres_u;
        off1  = hs(coef[0][31:16]);
        off2  = hs(coef[0][15:0]);
        sens3 = hs(coef[1][31:16]);
        gain5 = longint'(coef[2][31:16]);
        toff6 = longint'(coef[2][15:0]);
        sq1   = hs(coef[3][31:16]);
        sq2   = hs(coef[3][15:0]);
        crv   = hs(coef[4][31:16]);
        cofs  = hs(coef[4][15:0]);
        upv   = 32'(up_raw >> (8 - oss_lvl));
        r = '{tenths: '0, pascal: '0, stat: 1'b1};

        lin = wrap32((longint'(ut_raw) - toff6) * gain5) >>> 15;
        den = wrap32(lin + cofs);
        if (den == 0)
            return r;
        corr = wrap32(wrap32(crv * 2048) / den);
        b5v  = wrap32(lin + corr);
        tv   = wrap32(b5v + 8) >>> 4;
        if (tv > 32767)
            tv = 32767;
        if (tv < -32768)
            tv = -32768;

        d6  = wrap32(b5v - 4000);
        sqr = wrap32(d6 * d6) >>> 12;
        a   = wrap32(sq2 * sqr) >>> 11;
        b   = wrap32(off2 * d6) >>> 11;
        c   = wrap32(a + b);
        b3v = wrap32(wrap32(wrap32(off1 * 4 + c) * (longint'(1) << oss_lvl)) + 2) >>> 2;
        a   = wrap32(sens3 * d6) >>> 13;
        b   = wrap32(sq1 * sqr) >>> 16;
        c   = wrap32(a + b + 2) >>> 2;
        wide = (64'(coef[1][15:0]) * ((c + 32768) & 64'hFFFF_FFFF)) & 64'hFFFF_FFFF;
        b4v  = 32'(wide >> 15);
        if (b4v == 0)
            return r;
        b7v = 32'(64'(upv - b3v[31:0]) * 64'(32'd50000 >> oss_lvl));
        if (!b7v[31])
            pres_u = 32'((64'(b7v) * 2) / b4v);
        else
            pres_u = 32'(64'(b7v / b4v) * 2);
        pv = longint'($signed(pres_u));

        a   = wrap32((pv >>> 8) * (pv >>> 8));
        a   = wrap32(a * 3038) >>> 16;
        b   = wrap32(-7357 * pv) >>> 16;
        fin = wrap32(pv + (wrap32(a + b + 3791) >>> 4));
        r.tenths = 16'(tv);
        r.pascal = 32'(fin);
        r.stat   = 1'b0;
        return r;
    endfunction

    assign outstanding = due_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            coef[0] <= RESET_OFFSET;
            coef[1] <= RESET_SENSITIVITY;
            coef[2] <= RESET_TEMP_LINEAR;
            coef[3] <= RESET_PRESS_SQ;
            coef[4] <= RESET_TEMP_CURVE;
            oss_lvl <= RESET_OVERSAMPLE;
            due_q.delete();
            mismatches <= 0;
        end
        else
        begin
            if (sample.valid && sample.ready)
                due_q.push_back(compensate(sample.raw_temperature, sample.raw_pressure_bytes));
            if (result.valid && result.ready)
            begin
                if (due_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t unexpected result beat t=%0d p=%0d s=%0b", $realtime,
                                 result.temperature_tenths, result.pressure_pascal,
                                 result.status);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = due_q.pop_front();
                    if (want.tenths !== result.temperature_tenths ||
                        want.pascal !== result.pressure_pascal ||
                        want.stat !== result.status)
                    begin
                        if (mismatches < 10)
                            $display("%0t mismatch exp t=%0d p=%0d s=%0b got t=%0d p=%0d s=%0b",
                                     $realtime, want.tenths, want.pascal, want.stat,
                                     result.temperature_tenths, result.pressure_pascal,
                                     result.status);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            // Apply calibration writes; indexes past the oversampling register drop.
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index < CFG_OVERSAMPLE)
                    coef[cfg.index] <= cfg.data;
                else if (cfg.index == CFG_OVERSAMPLE)
                    oss_lvl <= cfg.data[1:0];
            end
        end
    end
endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import bsc_pkg::*;

    // Index values past the last register; a write there must be dropped.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 120;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   cycles;

    // Idle bursts on either side, shut off for the last phase.
    bit   idle_on;
    // Toggle to ask the result side for one long hold-off.
    bit   long_req;
    bit   long_seen;
    int   hold_left;

    bsc_sample_if sample_ch ();
    bsc_result_if result_ch ();
    bsc_cfg_if    cfg_ch ();

    barometric_sensor_compensation dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(sample_ch),
        .result(result_ch),
        .cfg   (cfg_ch)
    );

    bsc_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample_ch),
        .result     (result_ch),
        .cfg        (cfg_ch),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side: random stall bursts, plus one long hold counted here.
    always @(posedge clk)
    begin
        if (long_req != long_seen)
        begin
            long_seen <= long_req;
            hold_left <= LONG_HOLD;
            result_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            hold_left <= $urandom_range(1, 12) - 1;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    // Watchdog: a correct run ends far below this.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic load_calibration(input logic [31:0] offs, input logic [31:0] sens,
                                    input logic [31:0] tlin, input logic [31:0] psq,
                                    input logic [31:0] tcrv, input logic [1:0] oss);
        write_reg(CFG_OFFSET, offs);
        write_reg(CFG_SENSITIVITY, sens);
        write_reg(CFG_TEMP_LINEAR, tlin);
        write_reg(CFG_PRESS_SQ, psq);
        write_reg(CFG_TEMP_CURVE, tcrv);
        write_reg(CFG_OVERSAMPLE, {30'd0, oss});
    endtask

    // Offer one reading pair; valid stays high across back-to-back beats.
    task automatic send_reading(input logic [15:0] ut, input logic [23:0] up);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid              <= 1'b1;
        sample_ch.raw_temperature    <= ut;
        sample_ch.raw_pressure_bytes <= up;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid and hold until every outstanding result has come back.
    task automatic drain;
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic random_readings(input int count);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 2) == 0)
                send_reading(16'($urandom), 24'($urandom));
            else
                send_reading(16'($urandom_range(20000, 36000)),
                             24'($urandom_range(24'h500000, 24'hA00000)));
        end
    endtask

    // Small perturbation of the default calibration keeps results realistic.
    function automatic logic [31:0] nudge(input logic [31:0] base);
        return base ^ {8'd0, 8'($urandom_range(0, 255)), 8'd0, 8'($urandom_range(0, 255))};
    endfunction

    initial
    begin
        int sel;
        rst_n                        = 1'b0;
        sample_ch.valid              = 1'b0;
        sample_ch.raw_temperature    = '0;
        sample_ch.raw_pressure_bytes = '0;
        result_ch.ready              = 1'b0;
        cfg_ch.valid                 = 1'b0;
        cfg_ch.index                 = CFG_OFFSET;
        cfg_ch.data                  = '0;
        idle_on   = 1'b1;
        long_req  = 1'b0;
        long_seen = 1'b0;
        hold_left = 0;
        cycles    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes under the default calibration.
        send_reading(16'h0000, 24'h000000);
        send_reading(16'hFFFF, 24'hFFFFFF);
        send_reading(16'h0000, 24'hFFFFFF);
        send_reading(16'hFFFF, 24'h000000);
        send_reading(16'hAAAA, 24'h555555);
        send_reading(16'h5555, 24'hAAAAAA);
        send_reading(16'd27898, 24'd6102528);
        drain();

        // Temperature divisor zero: gain and curvature offset both zero.
        load_calibration(RESET_OFFSET, RESET_SENSITIVITY, 32'h0000_1234, RESET_PRESS_SQ,
                         32'h1234_0000, 2'd0);
        send_reading(16'd27898, 24'd6102528);
        send_reading(16'hFFFF, 24'hFFFFFF);
        drain();

        // Pressure divisor zero: sensitivity base zero.
        load_calibration(RESET_OFFSET, 32'hC7E5_0000, RESET_TEMP_LINEAR, RESET_PRESS_SQ,
                         RESET_TEMP_CURVE, 2'd1);
        send_reading(16'd27898, 24'd6102528);
        send_reading(16'h0000, 24'h000000);
        drain();

        // Temperature saturation high, then low: divisor of one, extreme curvature.
        load_calibration(RESET_OFFSET, RESET_SENSITIVITY, 32'h0000_0000, RESET_PRESS_SQ,
                         32'h7FFF_0001, 2'd2);
        send_reading(16'd100, 24'h123456);
        send_reading(16'hFFFF, 24'hFEDCBA);
        drain();
        load_calibration(RESET_OFFSET, RESET_SENSITIVITY, 32'h0000_0000, RESET_PRESS_SQ,
                         32'h8000_0001, 2'd3);
        send_reading(16'd100, 24'h123456);
        send_reading(16'h0000, 24'hFFFFFF);
        drain();

        // Out-of-range indexes must leave the calibration untouched.
        write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_B, 32'h0000_0000);
        send_reading(16'd27898, 24'd6102528);
        drain();

        // Calibration extremes: all zeros and all ones.
        load_calibration('0, '0, '0, '0, '0, 2'd0);
        random_readings(20);
        drain();
        load_calibration('1, '1, '1, '1, '1, 2'd3);
        random_readings(20);
        drain();

        // Long result hold-off: the block fills and backs up its input.
        load_calibration(RESET_OFFSET, RESET_SENSITIVITY, RESET_TEMP_LINEAR, RESET_PRESS_SQ,
                         RESET_TEMP_CURVE, RESET_OVERSAMPLE);
        long_req <= ~long_req;
        random_readings(150);
        drain();

        // Random phases: realistic and fully random calibrations.
        for (int ph = 0; ph < 6; ph++)
        begin
            sel = $urandom_range(0, 2);
            if (sel == 0)
                load_calibration($urandom, $urandom, $urandom, $urandom, $urandom,
                                 2'($urandom));
            else
                load_calibration(nudge(RESET_OFFSET), nudge(RESET_SENSITIVITY),
                                 nudge(RESET_TEMP_LINEAR), nudge(RESET_PRESS_SQ),
                                 nudge(RESET_TEMP_CURVE), 2'($urandom));
            if (ph == 5)
                idle_on = 1'b0;
            random_readings(70);
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
